[rtl/core/stsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_pkg
// Shared types and constants of the sorted key table with search and insert.
// ----------------------------------------------------------------------------
package stsi_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_W       = 40;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 4;
  localparam int OUT_DATA_W  = 8;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } res_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } ctrl_stat_t;

endpackage

[rtl/core/stsi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_ram
// Key store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stsi_ram (
  input  logic                     clk,
  input  stsi_pkg::ram_req_t       req,
  output logic [stsi_pkg::KEY_W-1:0] rd_data
);
  import stsi_pkg::*;

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/core/stsi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_ctrl
// Sequencer: binary search over the key store, then the upward shift and
// the write of a new key, with the entry count.
// ----------------------------------------------------------------------------
module stsi_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        start_cmd,
  input  logic [stsi_pkg::KEY_W-1:0]  start_key,
  output stsi_pkg::ram_req_t          ram_req,
  input  logic [stsi_pkg::KEY_W-1:0]  ram_rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output stsi_pkg::res_t              res,
  output stsi_pkg::ctrl_stat_t        stat
);
  import stsi_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CNT_W-1:0]    where_r, where_nxt, i_r, i_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                wpend_r, wpend_nxt;
  logic [IDX_W-1:0]    waddr_r, waddr_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    mid_calc, i_dec;

  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign i_dec    = i_r - CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    where_nxt  = where_r;
    i_nxt      = i_r;
    count_nxt  = count_r;
    wpend_nxt  = wpend_r;
    waddr_nxt  = waddr_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    ram_req    = '0;
    ram_req.rd_addr = mid_calc[IDX_W-1:0];
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = start_cmd;
          key_nxt   = start_key;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          ram_req.rd_en = 1'b1;
          mid_nxt       = mid_calc;
          state_nxt     = S_CMP;
        end else begin
          where_nxt = lo_r;
          if (cmd_r == CMD_LOOKUP) begin
            state_nxt = S_FIN;
            if (lo_r >= count_r) begin
              status_nxt = ST_BEYOND;
              pos_nxt    = '0;
            end else begin
              status_nxt = ST_ABSENT;
              pos_nxt    = lo_r;
            end
          end else if (count_r >= CNT_W'(TABLE_DEPTH)) begin
            status_nxt = ST_FULL;
            pos_nxt    = '0;
            state_nxt  = S_FIN;
          end else begin
            i_nxt     = count_r;
            wpend_nxt = 1'b0;
            state_nxt = S_SHIFT;
          end
        end
      end
      S_CMP: begin
        if (ram_rd_data == key_r) begin
          status_nxt = (cmd_r == CMD_LOOKUP) ? ST_FOUND : ST_DUP;
          pos_nxt    = mid_r;
          state_nxt  = S_FIN;
        end else begin
          if (ram_rd_data < key_r) begin
            lo_nxt = mid_r + CNT_W'(1);
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_SRCH;
        end
      end
      S_SHIFT: begin
        // The entry read last cycle lands one place higher; the next lower
        // entry is read in the same cycle, so one entry moves per cycle.
        ram_req.wr_en   = wpend_r;
        ram_req.wr_addr = waddr_r;
        ram_req.wr_data = ram_rd_data;
        ram_req.rd_addr = i_dec[IDX_W-1:0];
        if (i_r > where_r) begin
          ram_req.rd_en = 1'b1;
          wpend_nxt     = 1'b1;
          waddr_nxt     = i_r[IDX_W-1:0];
          i_nxt         = i_dec;
        end else begin
          wpend_nxt = 1'b0;
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = where_r[IDX_W-1:0];
        ram_req.wr_data = key_r;
        count_nxt       = count_r + CNT_W'(1);
        status_nxt      = ST_ABSENT;
        pos_nxt         = where_r;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status   = status_r;
  assign res.position = POS_W'(pos_r);
  assign stat.idle    = (state_r == S_IDLE);
  assign stat.count   = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      wpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wpend_r <= wpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    where_r  <= where_nxt;
    i_r      <= i_nxt;
    waddr_r  <= waddr_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

endmodule

[rtl/core/sorted_table_search_insert_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_search_insert_top
// Ascending key table with binary-search lookup and ordered insert.
// ----------------------------------------------------------------------------
// One beat in gives one beat out, and the block takes one command at a time.
// A command with n filled entries is taken in, then runs at most
// ceil(log2(n+1)) probes of the binary search, each a read of the key memory
// and its compare; a search that misses is then closed, and the result is
// handed over. A successful insert then moves each larger entry up one
// place, one entry per cycle with a read and a write of the key memory in the
// same cycle, then closes the shift and writes the new key. A result waits
// in the output register while the next command is accepted. No clearing
// pass follows reset: the entry count alone marks which entries hold keys.
module sorted_table_search_insert_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [stsi_pkg::KEY_W-1:0]      in_tdata,   // [39:0] key
  input  logic                            in_tuser,   // [0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [stsi_pkg::OUT_DATA_W-1:0] out_tdata,  // [3:0] position, [7:4] zero
  output logic [stsi_pkg::STATUS_W-1:0]   out_tuser   // [2:0] status
);
  import stsi_pkg::*;

  ram_req_t         ram_req;
  logic [KEY_W-1:0] ram_rd_data;
  logic             res_valid, res_ready;
  res_t             res;
  ctrl_stat_t       stat;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;

  assign in_tready = stat.idle;
  assign res_ready = !out_valid_r || out_tready;

  stsi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_tvalid && in_tready),
    .start_cmd   (in_tuser),
    .start_key   (in_tdata),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .stat        (stat)
  );

  stsi_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r.position);
  assign out_tuser  = out_res_r.status;

  // The entry count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // While the sequencer is free to take a command it offers no result.
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("result offered while idle");

  // Beyond-end and full results carry position zero.
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_BEYOND || out_tuser == ST_FULL))
      |-> (out_tdata == '0))
    else $error("nonzero position on beyond-end or full result");

  // Keys are only written inside the filled entries or the slot just past them.
  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> (CNT_W'(ram_req.wr_addr) <= stat.count))
    else $error("key written beyond the filled entries");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key table with search and insert.
// ----------------------------------------------------------------------------
// A queue of lookup and insert commands is filled up front: a directed part
// that walks the empty, append, front, middle, duplicate and full cases, then
// random commands whose keys are mostly drawn from keys already used, their
// neighbours and the extremes. A clocked driver offers the commands, and at
// each accepted beat a model of the table predicts the result. A clocked
// monitor compares every result beat with the oldest prediction. Both sides
// idle at random in the first two of three phases, and once the receiver holds off for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import stsi_pkg::*;

  localparam int N_RANDOM    = 750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 620;

  typedef struct {
    logic             cmd;
    logic [KEY_W-1:0] key;
  } cmd_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [KEY_W-1:0]      in_tdata = '0;
  logic                  in_tuser = CMD_LOOKUP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  cmd_beat_t        pending_cmds[$];
  logic [KEY_W-1:0] used_keys[$];
  res_t             due_results[$];

  // Table as the bench believes it to be.
  logic [KEY_W-1:0] model_keys[TABLE_DEPTH];
  int               model_count = 0;

  int n_accepted = 0;
  int err_count  = 0;
  int cycles     = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  sorted_table_search_insert_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Binary search of the filled entries, then the lookup or insert outcome.
  function automatic res_t table_apply(input logic cmd, input logic [KEY_W-1:0] key);
    int   lo;
    int   hi;
    int   mid;
    int   where;
    bit   hit;
    res_t r;
    lo  = 0;
    hi  = model_count;
    hit = 1'b0;
    mid = 0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (model_keys[mid] == key) begin
        hit = 1'b1;
      end else if (model_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    where = hit ? mid : lo;
    if (cmd == CMD_LOOKUP) begin
      if (hit) begin
        r.status = ST_FOUND;
        r.position = where[POS_W-1:0];
      end else if (where >= model_count) begin
        r.status = ST_BEYOND;
        r.position = '0;
      end else begin
        r.status = ST_ABSENT;
        r.position = where[POS_W-1:0];
      end
    end else begin
      if (hit) begin
        r.status = ST_DUP;
        r.position = where[POS_W-1:0];
      end else if (model_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
        r.position = '0;
      end else begin
        for (int i = model_count; i > where; i--) begin
          model_keys[i] = model_keys[i-1];
        end
        model_keys[where] = key;
        model_count++;
        r.status = ST_ABSENT;
        r.position = where[POS_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[KEY_W-1:0];
  endfunction

  // Mostly keys that hit or sit right beside an existing one.
  function automatic logic [KEY_W-1:0] pick_key();
    int               roll;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(99);
    if (used_keys.size() == 0 || roll >= 65) begin
      k = rand_key();
    end else if (roll < 45) begin
      k = used_keys[$urandom_range(used_keys.size() - 1)];
    end else if (roll < 60) begin
      k = used_keys[$urandom_range(used_keys.size() - 1)];
      k = $urandom_range(1) ? k + 1'b1 : k - 1'b1;
    end else begin
      k = $urandom_range(1) ? '1 : '0;
    end
    return k;
  endfunction

  task automatic queue_cmd(input logic cmd, input logic [KEY_W-1:0] key);
    cmd_beat_t b;
    b.cmd = cmd;
    b.key = key;
    pending_cmds.push_back(b);
    used_keys.push_back(key);
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want_v);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got,
             want_v);
    err_count++;
  endtask

  // Sender idles mostly in the second phase, receiver mostly in the first, neither after.
  function automatic int tx_idle_pct();
    return (n_accepted < 250) ? 20 : (n_accepted < 500) ? 71 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (n_accepted < 250) ? 71 : (n_accepted < 500) ? 20 : 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(table_apply(in_tuser, in_tdata));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_cmds[0].cmd;
          in_tdata  <= pending_cmds[0].key;
          void'(pending_cmds.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering beats.
  always @(posedge clk) begin
    if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor_proc
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result beat, status", {5'd0, out_tuser}, 8'd0);
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.status) begin
            report_mismatch("status", {5'd0, out_tuser}, {5'd0, want.status});
          end
          if (out_tdata[POS_W-1:0] !== want.position) begin
            report_mismatch("position", {4'd0, out_tdata[POS_W-1:0]}, {4'd0, want.position});
          end
          if (out_tdata[OUT_DATA_W-1:POS_W] !== '0) begin
            report_mismatch("tdata padding", {4'd0, out_tdata[OUT_DATA_W-1:POS_W]}, 8'd0);
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** sorted_table_search_insert_top: FAILED **");
      $finish;
    end
  end

  initial begin
    // Empty table, then front, append and middle inserts with shifts.
    queue_cmd(CMD_LOOKUP, '0);
    queue_cmd(CMD_LOOKUP, '1);
    queue_cmd(CMD_INSERT, '0);
    queue_cmd(CMD_LOOKUP, 40'h00_0000_0005);
    queue_cmd(CMD_INSERT, '1);
    queue_cmd(CMD_INSERT, 40'h80_0000_0000);
    queue_cmd(CMD_INSERT, '0);
    queue_cmd(CMD_LOOKUP, '0);
    queue_cmd(CMD_LOOKUP, '1);
    queue_cmd(CMD_LOOKUP, 40'h00_0000_0001);
    queue_cmd(CMD_INSERT, 40'h7F_FFFF_FFFF);
    queue_cmd(CMD_INSERT, 40'h00_0000_0001);
    queue_cmd(CMD_INSERT, 40'hAA_AAAA_AAAA);
    queue_cmd(CMD_INSERT, 40'h55_5555_5555);
    // Fill the remaining slots, then probe the full table.
    for (int i = 0; i < TABLE_DEPTH - 7; i++) begin
      queue_cmd(CMD_INSERT, rand_key());
    end
    queue_cmd(CMD_INSERT, rand_key());
    queue_cmd(CMD_INSERT, '0);
    queue_cmd(CMD_INSERT, '1);
    queue_cmd(CMD_LOOKUP, '1);

    for (int i = 0; i < N_RANDOM; i++) begin
      queue_cmd($urandom_range(1) ? CMD_INSERT : CMD_LOOKUP, pick_key());
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_tvalid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    if (due_results.size() != 0) begin
      $display("%0d expected results never arrived", due_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("** sorted_table_search_insert_top: PASSED **");
    end else begin
      $display("** sorted_table_search_insert_top: FAILED **");
    end
    $finish;
  end

endmodule

[sorted_table_search_insert_top.f]
rtl/core/stsi_pkg.sv
rtl/core/stsi_ram.sv
rtl/core/stsi_ctrl.sv
rtl/core/sorted_table_search_insert_top.sv
bench/tb_top.sv
